>>> rtl/core/vbr_pkg.sv
// Shared types, constants and helpers for the PCM volume/balance resampler.
// Depends on nothing; used by vbr_muldiv and pcm_volume_balance_resampler.

package vbr_pkg;

   localparam int unsigned OutputRate    = 48000;
   localparam int unsigned FractionScale = 32768;
   localparam int unsigned MinInputRate  = 8000;
   localparam int unsigned MaxOutFrames  = 6;

   localparam logic [2:0] CSR_VOLUME     = 3'd0;
   localparam logic [2:0] CSR_BALANCE    = 3'd1;
   localparam logic [2:0] CSR_INPUT_RATE = 3'd2;
   localparam logic [2:0] CSR_MONO       = 3'd3;
   localparam logic [2:0] CSR_LED_LOW    = 3'd4;

   typedef struct packed {
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic               buffer_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               last;
      logic [7:0]         led_duty;
   } rsp_payload_type;

   // One operation of the serial unit: (a * m + h) / d, truncated.
   typedef struct packed {
      logic [15:0] a;
      logic [15:0] m;
      logic [15:0] h;
      logic [15:0] d;
   } md_cmd_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) r = 16'sh7fff;
      else if (v < -18'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      logic [15:0] r;
      r = v[15] ? 16'(-v) : 16'(v);
      return r;
   endfunction

endpackage

>>> rtl/core/vbr_muldiv.sv
// Bit-serial multiply-add then restoring divide: q = (a*m + h) / d.
// Depends on vbr_pkg (md_cmd_type). The multiply phase runs first, then the divide phase.

module vbr_muldiv import vbr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  md_cmd_type cmd,
   output logic       done,
   output logic [16:0] quot
);

   logic [31:0] mcand_ff, mcand_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        dphase_ff, dphase_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic        fits;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      dphase_in = dphase_ff;
      done_in   = 1'b0;
      trial     = {rem_ff, acc_ff[31]};
      fits      = trial >= {1'b0, div_ff};
      if (start) begin
         mcand_in  = {16'd0, cmd.a};
         mplier_in = cmd.m;
         acc_in    = {16'd0, cmd.h};
         div_in    = cmd.d;
         rem_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
         dphase_in = 1'b0;
      end else if (busy_ff && !dphase_ff) begin
         // consume one multiplier bit
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = {mcand_ff[30:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[15:1]};
         cnt_in    = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            dphase_in = 1'b1;
            cnt_in    = '0;
         end
      end else if (busy_ff) begin
         // one quotient bit, shifted in behind the dividend
         acc_in = {acc_ff[30:0], fits};
         rem_in = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      cnt_ff    <= cnt_in;
      dphase_ff <= dphase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = acc_ff[16:0];

endmodule

>>> rtl/core/pcm_volume_balance_resampler.sv
// Top level: volume, balance, linear resampler to 48 kHz and LED level meter.
// Depends on vbr_pkg and vbr_muldiv.

// Each accepted transaction is one stereo frame. It is scaled by volume/254,
// attenuated on one side by balance, and resampled linearly to 48 kHz,
// producing one to six result transactions, the final one flagged by last.
// All multiplications and divisions run through one bit-serial
// multiply/divide unit; a frame costs two volume operations, one balance
// operation when balance is nonzero, one LED operation on buffer_end, and
// three operations per interpolated output frame. At 48 kHz input the
// resampler is bypassed. The request channel stalls during reset and while a
// frame is being worked; the result register frees the block to accept the
// next frame while the final result waits. The CSR port is ready whenever
// reset is low and must only be written while idle.

module pcm_volume_balance_resampler import vbr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_VOL_L, ST_VOL_R, ST_BAL, ST_PEAK, ST_LED,
      ST_ROUTE, ST_FRAC, ST_INT_L, ST_INT_R, ST_EMIT
   } state_type;

   localparam logic [16:0] OutRate17 = 17'(OutputRate);

   state_type        state_ff, state_in;
   logic             go_ff, go_in;
   logic signed [15:0] left_ff, left_in, right_ff, right_in;
   logic             bend_ff, bend_in;
   logic [15:0]      peak_ff, peak_in;
   logic [7:0]       env_ff, env_in;
   logic             hvalid_ff, hvalid_in;
   logic signed [15:0] hist_l_ff, hist_l_in, hist_r_ff, hist_r_in;
   logic [15:0]      nphase_ff, nphase_in;
   logic [15:0]      phase_ff, phase_in;
   logic [15:0]      frac_ff, frac_in;
   logic signed [15:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic             olast_ff, olast_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             rvalid_ff, rvalid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic [7:0]       vol_ff, vol_in;
   logic signed [5:0] bal_ff, bal_in;
   logic [15:0]      rate_ff, rate_in;
   logic             mono_ff, mono_in;
   logic             alow_ff, alow_in;
   // set when the current frame went through the interpolation path
   logic             interp_ff, interp_in;

   md_cmd_type       cmd;
   logic             md_start, md_done;
   logic [16:0]      md_quot;
   logic             op_sign;
   logic signed [17:0] sq;
   logic signed [5:0] bclamp;
   logic [4:0]       att;
   logic signed [16:0] diff_l, diff_r;
   logic [15:0]      pk;
   logic [7:0]       target;
   logic [16:0]      phase_nx;
   logic             out_free;

   vbr_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .cmd   (cmd),
      .done  (md_done),
      .quot  (md_quot)
   );

   // balance limited to sixteenths; attenuation factor is 16 - |balance|
   always_comb begin
      if (bal_ff < -6'sd16) bclamp = -6'sd16;
      else if (bal_ff > 6'sd16) bclamp = 6'sd16;
      else bclamp = bal_ff;
      att = bclamp[5] ? 5'(6'sd16 + bclamp) : 5'(6'sd16 - bclamp);
   end

   assign diff_l   = {left_ff[15], left_ff} - {hist_l_ff[15], hist_l_ff};
   assign diff_r   = {right_ff[15], right_ff} - {hist_r_ff[15], hist_r_ff};
   assign phase_nx = {1'b0, phase_ff} + {1'b0, rate_ff};
   assign out_free = !rvalid_ff || !rsp_stall;
   assign pk       = (mag16(left_ff) > mag16(right_ff)) ? mag16(left_ff)
                                                        : mag16(right_ff);
   assign target   = (md_quot > 17'd255) ? 8'hff : md_quot[7:0];

   // operand select for the serial unit
   always_comb begin
      cmd     = '0;
      op_sign = 1'b0;
      case (state_ff)
         ST_VOL_L: begin
            cmd     = '{a: mag16(left_ff), m: {8'd0, vol_ff}, h: 16'd127, d: 16'd254};
            op_sign = left_ff[15];
         end
         ST_VOL_R: begin
            cmd     = '{a: mag16(right_ff), m: {8'd0, vol_ff}, h: 16'd127, d: 16'd254};
            op_sign = right_ff[15];
         end
         ST_BAL: begin
            cmd.a   = bclamp[5] ? mag16(right_ff) : mag16(left_ff);
            cmd.m   = {11'd0, att};
            cmd.h   = 16'd8;
            cmd.d   = 16'd16;
            op_sign = bclamp[5] ? right_ff[15] : left_ff[15];
         end
         ST_LED: begin
            cmd = '{a: peak_ff, m: 16'd255, h: 16'd16384, d: 16'd32768};
         end
         ST_FRAC: begin
            cmd = '{a: phase_ff, m: 16'(FractionScale), h: 16'(OutputRate / 2),
                    d: 16'(OutputRate)};
         end
         ST_INT_L: begin
            cmd.a   = diff_l[16] ? 16'(-diff_l) : diff_l[15:0];
            cmd.m   = frac_ff;
            cmd.h   = 16'(FractionScale / 2);
            cmd.d   = 16'(FractionScale);
            op_sign = diff_l[16];
         end
         ST_INT_R: begin
            cmd.a   = diff_r[16] ? 16'(-diff_r) : diff_r[15:0];
            cmd.m   = frac_ff;
            cmd.h   = 16'(FractionScale / 2);
            cmd.d   = 16'(FractionScale);
            op_sign = diff_r[16];
         end
         default: ;
      endcase
      sq = op_sign ? -$signed({1'b0, md_quot}) : $signed({1'b0, md_quot});
   end

   assign md_start = !go_ff && (state_ff inside {ST_VOL_L, ST_VOL_R, ST_BAL, ST_LED,
                                                 ST_FRAC, ST_INT_L, ST_INT_R});

   always_comb begin
      state_in  = state_ff;
      go_in     = go_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      bend_in   = bend_ff;
      peak_in   = peak_ff;
      env_in    = env_ff;
      hvalid_in = hvalid_ff;
      hist_l_in = hist_l_ff;
      hist_r_in = hist_r_ff;
      nphase_in = nphase_ff;
      phase_in  = phase_ff;
      frac_in   = frac_ff;
      out_l_in  = out_l_ff;
      out_r_in  = out_r_ff;
      olast_in  = olast_ff;
      cnt_in    = cnt_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rsp_in    = rsp_ff;
      vol_in    = vol_ff;
      bal_in    = bal_ff;
      rate_in   = rate_ff;
      mono_in   = mono_ff;
      alow_in   = alow_ff;

      if (md_start) go_in = 1'b1;
      if (md_done) go_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               left_in  = req_payload.left_in;
               right_in = mono_ff ? req_payload.left_in : req_payload.right_in;
               bend_in  = req_payload.buffer_end;
               state_in = ST_VOL_L;
            end
         end
         ST_VOL_L: begin
            if (md_done) begin
               left_in  = sat16(sq);
               state_in = ST_VOL_R;
            end
         end
         ST_VOL_R: begin
            if (md_done) begin
               right_in = sat16(sq);
               state_in = (bclamp != 6'sd0) ? ST_BAL : ST_PEAK;
            end
         end
         ST_BAL: begin
            if (md_done) begin
               if (bclamp[5]) right_in = sat16(sq);
               else left_in = sat16(sq);
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            if (pk > peak_ff) peak_in = pk;
            state_in = bend_ff ? ST_LED : ST_ROUTE;
         end
         ST_LED: begin
            if (md_done) begin
               // attack at once, decay by four per buffer
               if (target >= env_ff) env_in = target;
               else if (env_ff > 8'd4) env_in = env_ff - 8'd4;
               else env_in = '0;
               peak_in  = '0;
               state_in = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            out_l_in = left_ff;
            out_r_in = right_ff;
            olast_in = 1'b1;
            cnt_in   = '0;
            if (rate_ff == 16'(OutputRate)) begin
               state_in = ST_EMIT;
            end else if (!hvalid_ff) begin
               hvalid_in = 1'b1;
               hist_l_in = left_ff;
               hist_r_in = right_ff;
               nphase_in = rate_ff;
               state_in  = ST_EMIT;
            end else begin
               phase_in = nphase_ff;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (md_done) begin
               frac_in  = md_quot[15:0];
               state_in = ST_INT_L;
            end
         end
         ST_INT_L: begin
            if (md_done) begin
               out_l_in = sat16($signed({{2{hist_l_ff[15]}}, hist_l_ff}) + sq);
               state_in = ST_INT_R;
            end
         end
         ST_INT_R: begin
            if (md_done) begin
               out_r_in = sat16($signed({{2{hist_r_ff[15]}}, hist_r_ff}) + sq);
               olast_in = (phase_nx > OutRate17) ||
                          (cnt_ff == 3'(MaxOutFrames - 1));
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rvalid_in          = 1'b1;
               rsp_in.left_out    = out_l_ff;
               rsp_in.right_out   = out_r_ff;
               rsp_in.last        = olast_ff;
               rsp_in.led_duty    = alow_ff ? ~env_ff : env_ff;
               if (olast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_nx[15:0];
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = ST_FRAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // history update at the end of an interpolated frame
      if (state_ff == ST_EMIT && out_free && olast_ff && interp_ff) begin
         nphase_in = 16'(phase_nx - OutRate17);
         hist_l_in = left_ff;
         hist_r_in = right_ff;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_VOLUME:  vol_in  = csr_data[7:0];
            CSR_BALANCE: bal_in  = csr_data[5:0];
            CSR_INPUT_RATE: begin
               if (csr_data >= 16'(MinInputRate) && csr_data <= 16'(OutputRate)) begin
                  rate_in   = csr_data;
                  hvalid_in = 1'b0;
                  hist_l_in = '0;
                  hist_r_in = '0;
                  nphase_in = '0;
               end
            end
            CSR_MONO:    mono_in = csr_data[0];
            CSR_LED_LOW: alow_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      interp_in = interp_ff;
      if (state_ff == ST_ROUTE) interp_in = 1'b0;
      if (state_ff == ST_FRAC) interp_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      bend_ff  <= bend_in;
      phase_ff <= phase_in;
      frac_ff  <= frac_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      olast_ff <= olast_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         go_ff     <= 1'b0;
         interp_ff <= 1'b0;
         peak_ff   <= '0;
         env_ff    <= '0;
         hvalid_ff <= 1'b0;
         hist_l_ff <= '0;
         hist_r_ff <= '0;
         nphase_ff <= '0;
         rvalid_ff <= 1'b0;
         vol_ff    <= 8'd192;
         bal_ff    <= '0;
         rate_ff   <= 16'(OutputRate);
         mono_ff   <= 1'b0;
         alow_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         go_ff     <= go_in;
         interp_ff <= interp_in;
         peak_ff   <= peak_in;
         env_ff    <= env_in;
         hvalid_ff <= hvalid_in;
         hist_l_ff <= hist_l_in;
         hist_r_ff <= hist_r_in;
         nphase_ff <= nphase_in;
         rvalid_ff <= rvalid_in;
         vol_ff    <= vol_in;
         bal_ff    <= bal_in;
         rate_ff   <= rate_in;
         mono_ff   <= mono_in;
         alow_ff   <= alow_in;
      end
   end

   assign req_stall   = reset || (state_ff != ST_IDLE);
   assign rsp_valid   = rvalid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = !reset;

endmodule
